FILE: rtl/extent_file_allocator_defines.svh
// assertion macros for the extent file allocator
`ifndef EXTENT_FILE_ALLOCATOR_DEFINES_SVH
`define EXTENT_FILE_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define EFA_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define EFA_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define EFA_ASSERT(name, expr, msg)
`define EFA_ASSERT_IMP(name, pre, post, msg)
`endif

`endif

FILE: rtl/efa_pkg.sv
package efa_pkg;

  localparam int MAX_FILES  = 1024;
  localparam int MAX_PIECES = 32;
  localparam int HEAP_DEPTH = 1024;

  localparam int CMD_W  = 2;
  localparam int ID_W   = 31;
  localparam int SIZE_W = 24;
  localparam int UNIT_W = 24;
  localparam int END_W  = 25;
  localparam int FREE_W = 25;
  localparam int ANS_W  = 26;

  localparam int FILE_AW  = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int SLOT_W   = $clog2(MAX_FILES + 1);
  localparam int PIECE_AW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
  localparam int PCNT_W   = $clog2(MAX_PIECES + 1);
  localparam int PCE_AW   = FILE_AW + PIECE_AW;
  localparam int HEAP_AW  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int HCNT_W   = $clog2(HEAP_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd2;

  localparam logic [SIZE_W-1:0] DISK_RESET = 24'd1048576;

  typedef struct packed {
    logic [END_W-1:0]  hi;
    logic [UNIT_W-1:0] lo;
  } ext_t;

  localparam int EXT_W = $bits(ext_t);

  typedef enum logic [1:0] {
    HOP_CLEAR,
    HOP_PUSH,
    HOP_POP
  } heap_op_t;

  typedef struct packed {
    logic     valid;
    heap_op_t op;
    ext_t     ext;
  } heap_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    ext_t              ext;
    logic [HCNT_W-1:0] count;
  } heap_rsp_t;

  typedef enum logic [3:0] {
    H_IDLE,
    H_POP_RD,
    H_POP_LAST,
    H_SD_NEXT,
    H_SD_C1,
    H_SD_C2,
    H_SD_CMP,
    H_SU,
    H_SU_CMP,
    H_DONE
  } hstate_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_INIT_W,
    S_SEED_W,
    S_IDLE,
    S_DISPATCH,
    S_FIND,
    S_FIND_CMP,
    S_FOUND,
    S_ADD_LOOP,
    S_ADD_POP,
    S_ADD_STEP,
    S_ADD_PUSHW,
    S_ADD_COMMIT,
    S_CP,
    S_CP_WR,
    S_RB,
    S_RB_PUSH,
    S_RB_W,
    S_RM_N,
    S_RM_RD,
    S_RM_PUSH,
    S_RM_W,
    S_CNT_SLOT,
    S_CNT_N,
    S_CNT_RD,
    S_CNT_CMP,
    S_EMIT
  } state_t;

endpackage

FILE: rtl/efa_if.sv
interface efa_item_if import efa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ID_W-1:0]   file_id;
  logic [SIZE_W-1:0] file_size;
  logic [UNIT_W-1:0] range_start;
  logic [UNIT_W-1:0] range_end;

  modport source (output valid, command, file_id, file_size, range_start, range_end,
                  input ready);
  modport sink (input valid, command, file_id, file_size, range_start, range_end,
                output ready);
endinterface

interface efa_result_if import efa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ANS_W-1:0] answer;
  logic                    overflow;

  modport source (output valid, answer, overflow, input ready);
  modport sink (input valid, answer, overflow, output ready);
endinterface

interface efa_cfg_if import efa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] disk_size;

  modport source (output valid, disk_size, input ready);
  modport sink (input valid, disk_size, output ready);
endinterface

FILE: rtl/efa_ram.sv
module efa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/efa_heap.sv
module efa_heap import efa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  heap_req_t req,
  output heap_rsp_t rsp
);

  localparam int C_W = HEAP_AW + 2;

  hstate_t state, state_next;
  logic [HCNT_W-1:0] count, count_next;
  logic [HEAP_AW-1:0] idx, idx_next, midx, midx_next;
  ext_t x, x_next, m, m_next, top, top_next;

  logic               we;
  logic [HEAP_AW-1:0] waddr, raddr;
  ext_t               wdata, rdata;

  logic [C_W-1:0]     c1, c2, cnt_ext;
  logic [HEAP_AW-1:0] idx_m1, pidx;

  efa_ram #(.WIDTH(EXT_W), .DEPTH(HEAP_DEPTH)) u_heap_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign c1      = C_W'({idx, 1'b1});
  assign c2      = c1 + C_W'(1);
  assign cnt_ext = C_W'(count);
  assign idx_m1  = idx - HEAP_AW'(1);
  assign pidx    = idx_m1 >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx  <= idx_next;
    midx <= midx_next;
    x    <= x_next;
    m    <= m_next;
    top  <= top_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    midx_next  = midx;
    x_next     = x;
    m_next     = m;
    top_next   = top;
    we         = 1'b0;
    waddr      = idx;
    wdata      = x;
    raddr      = '0;
    unique case (state)
      H_IDLE: begin
        if (req.valid) begin
          unique case (req.op)
            HOP_CLEAR: begin
              count_next = '0;
              state_next = H_DONE;
            end
            HOP_POP: begin
              raddr      = '0;
              count_next = count - HCNT_W'(1);
              state_next = H_POP_RD;
            end
            HOP_PUSH: begin
              if (count >= HCNT_W'(HEAP_DEPTH)) begin
                state_next = H_DONE;
              end else begin
                idx_next   = count[HEAP_AW-1:0];
                x_next     = req.ext;
                count_next = count + HCNT_W'(1);
                state_next = H_SU;
              end
            end
            default: state_next = H_DONE;
          endcase
        end
      end
      H_POP_RD: begin
        top_next   = rdata;
        raddr      = count[HEAP_AW-1:0];
        state_next = H_POP_LAST;
      end
      H_POP_LAST: begin
        x_next     = rdata;
        idx_next   = '0;
        state_next = H_SD_NEXT;
      end
      H_SD_NEXT: begin
        if (c1 < cnt_ext) begin
          raddr      = c1[HEAP_AW-1:0];
          state_next = H_SD_C1;
        end else begin
          we         = 1'b1;
          state_next = H_DONE;
        end
      end
      H_SD_C1: begin
        m_next    = rdata;
        midx_next = c1[HEAP_AW-1:0];
        if (c2 < cnt_ext) begin
          raddr      = c2[HEAP_AW-1:0];
          state_next = H_SD_C2;
        end else begin
          state_next = H_SD_CMP;
        end
      end
      H_SD_C2: begin
        if (m.lo > rdata.lo) begin
          m_next    = rdata;
          midx_next = c2[HEAP_AW-1:0];
        end
        state_next = H_SD_CMP;
      end
      H_SD_CMP: begin
        we = 1'b1;
        if (x.lo > m.lo) begin
          wdata      = m;
          idx_next   = midx;
          state_next = H_SD_NEXT;
        end else begin
          state_next = H_DONE;
        end
      end
      H_SU: begin
        if (idx == '0) begin
          we         = 1'b1;
          state_next = H_DONE;
        end else begin
          raddr      = pidx;
          state_next = H_SU_CMP;
        end
      end
      H_SU_CMP: begin
        we = 1'b1;
        if (rdata.lo > x.lo) begin
          wdata      = rdata;
          idx_next   = pidx;
          state_next = H_SU;
        end else begin
          state_next = H_DONE;
        end
      end
      H_DONE: state_next = H_IDLE;
      default: state_next = H_IDLE;
    endcase
  end

  assign rsp.done  = (state == H_DONE);
  assign rsp.busy  = (state != H_IDLE);
  assign rsp.ext   = top;
  assign rsp.count = count;

endmodule

FILE: rtl/extent_file_allocator.sv
// channel  | dir | payload
// item     | in  | command, file_id, file_size, range_start, range_end
// result   | out | answer, overflow
// cfg      | in  | disk_size
// add: searches the used slots for the id, takes extents from the free heap,
//   then stores the pieces
// remove: the id search, then one heap push (a sift-up) per piece returned
// count: scans each used slot and reads its pieces until one overlaps the range; the heap
//   engine is shared by seeding, add and remove, and each table has a single read port
// after reset or a cfg write the block clears and seeds the heap before taking items
// a result waiting on result.ready holds the block until the output register frees
`include "extent_file_allocator_defines.svh"

module extent_file_allocator import efa_pkg::*; (
  input logic          clk,
  input logic          rst,
  efa_item_if.sink     item,
  efa_result_if.source result,
  efa_cfg_if.sink      cfg
);

  state_t state, state_next;

  logic [SIZE_W-1:0] disk_size, disk_size_next;
  logic [FREE_W-1:0] free_units, free_units_next;
  logic [SLOT_W-1:0] slots_used, slots_used_next;
  logic [CMD_W-1:0]  cmd, cmd_next;
  logic [ID_W-1:0]   fid, fid_next;
  logic [SIZE_W-1:0] fsize, fsize_next;
  logic [UNIT_W-1:0] rs, rs_next;
  logic [END_W-1:0]  hi_q, hi_q_next;
  logic [SLOT_W-1:0] scan, scan_next;
  logic [FILE_AW-1:0] slot, slot_next;
  logic              found, found_next;
  logic [PCNT_W-1:0] n, n_next, j, j_next;
  logic [HCNT_W-1:0] pops, pops_next, k, k_next;
  logic [SIZE_W-1:0] rem, rem_next, take, take_next;
  ext_t              pop, pop_next, last, last_next;
  logic [UNIT_W-1:0] first_lo, first_lo_next;
  logic [SLOT_W-1:0] total, total_next;
  logic [ANS_W-1:0]  ans, ans_next;
  logic              ovf, ovf_next;
  logic              res_valid, res_valid_next, load;

  heap_req_t hreq;
  heap_rsp_t hrsp;

  logic               id_we, sz_we, pc_we, pce_we, stg_we, log_we;
  logic [FILE_AW-1:0] id_waddr, id_raddr, sz_waddr, sz_raddr, pc_waddr, pc_raddr;
  logic [ID_W-1:0]    id_rdata;
  logic [SIZE_W-1:0]  sz_wdata, sz_rdata;
  logic [PCNT_W-1:0]  pc_wdata, pc_rdata;
  logic [PCE_AW-1:0]  pce_waddr, pce_raddr;
  ext_t               pce_wdata, pce_rdata, stg_rdata, log_rdata;
  logic [PIECE_AW-1:0] stg_waddr, stg_raddr;
  logic [HEAP_AW-1:0] log_waddr, log_raddr;

  logic [END_W-1:0]    span, end_v, r_v;
  logic [UNIT_W-1:0]   l_v;
  logic [PCNT_W-1:0]   n_m1;
  logic [HCNT_W:0]     heap_need;
  logic [FILE_AW-1:0]  slot_c;

  efa_heap u_heap (
    .clk (clk),
    .rst (rst),
    .req (hreq),
    .rsp (hrsp)
  );

  efa_ram #(.WIDTH(ID_W), .DEPTH(MAX_FILES)) u_id_ram (
    .clk (clk), .we (id_we), .waddr (id_waddr), .wdata (fid),
    .raddr (id_raddr), .rdata (id_rdata)
  );

  efa_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_FILES)) u_sz_ram (
    .clk (clk), .we (sz_we), .waddr (sz_waddr), .wdata (sz_wdata),
    .raddr (sz_raddr), .rdata (sz_rdata)
  );

  efa_ram #(.WIDTH(PCNT_W), .DEPTH(MAX_FILES)) u_pc_ram (
    .clk (clk), .we (pc_we), .waddr (pc_waddr), .wdata (pc_wdata),
    .raddr (pc_raddr), .rdata (pc_rdata)
  );

  efa_ram #(.WIDTH(EXT_W), .DEPTH(2 ** PCE_AW)) u_pce_ram (
    .clk (clk), .we (pce_we), .waddr (pce_waddr), .wdata (pce_wdata),
    .raddr (pce_raddr), .rdata (pce_rdata)
  );

  efa_ram #(.WIDTH(EXT_W), .DEPTH(MAX_PIECES)) u_stg_ram (
    .clk (clk), .we (stg_we), .waddr (stg_waddr), .wdata (last),
    .raddr (stg_raddr), .rdata (stg_rdata)
  );

  efa_ram #(.WIDTH(EXT_W), .DEPTH(HEAP_DEPTH)) u_log_ram (
    .clk (clk), .we (log_we), .waddr (log_waddr), .wdata (hrsp.ext),
    .raddr (log_raddr), .rdata (log_rdata)
  );

  assign span      = hrsp.ext.hi - END_W'(hrsp.ext.lo);
  assign end_v     = END_W'(pop.lo) + END_W'(take);
  assign l_v       = (pce_rdata.lo > rs) ? pce_rdata.lo : rs;
  assign r_v       = (pce_rdata.hi < hi_q) ? pce_rdata.hi : hi_q;
  assign n_m1      = n - PCNT_W'(1);
  assign heap_need = (HCNT_W + 1)'(hrsp.count) + (HCNT_W + 1)'(pc_rdata);
  assign slot_c    = found ? slot : slots_used[FILE_AW-1:0];

  assign item.ready      = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready       = (state == S_IDLE);
  assign load            = (state == S_EMIT) && (!res_valid || result.ready);
  assign res_valid_next  = load || (res_valid && !result.ready);
  assign result.valid    = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      disk_size <= DISK_RESET;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      disk_size <= disk_size_next;
      res_valid <= res_valid_next;
    end
    if (load) begin
      result.answer   <= ans;
      result.overflow <= ovf;
    end
    free_units <= free_units_next;
    slots_used <= slots_used_next;
    cmd        <= cmd_next;
    fid        <= fid_next;
    fsize      <= fsize_next;
    rs         <= rs_next;
    hi_q       <= hi_q_next;
    scan       <= scan_next;
    slot       <= slot_next;
    found      <= found_next;
    n          <= n_next;
    j          <= j_next;
    pops       <= pops_next;
    k          <= k_next;
    rem        <= rem_next;
    take       <= take_next;
    pop        <= pop_next;
    last       <= last_next;
    first_lo   <= first_lo_next;
    total      <= total_next;
    ans        <= ans_next;
    ovf        <= ovf_next;
  end

  always_comb begin
    state_next      = state;
    disk_size_next  = disk_size;
    free_units_next = free_units;
    slots_used_next = slots_used;
    cmd_next        = cmd;
    fid_next        = fid;
    fsize_next      = fsize;
    rs_next         = rs;
    hi_q_next       = hi_q;
    scan_next       = scan;
    slot_next       = slot;
    found_next      = found;
    n_next          = n;
    j_next          = j;
    pops_next       = pops;
    k_next          = k;
    rem_next        = rem;
    take_next       = take;
    pop_next        = pop;
    last_next       = last;
    first_lo_next   = first_lo;
    total_next      = total;
    ans_next        = ans;
    ovf_next        = ovf;
    hreq            = '0;
    id_we     = 1'b0;
    id_waddr  = slot_c;
    id_raddr  = scan[FILE_AW-1:0];
    sz_we     = 1'b0;
    sz_waddr  = slot_c;
    sz_wdata  = fsize;
    sz_raddr  = slot;
    pc_we     = 1'b0;
    pc_waddr  = slot_c;
    pc_wdata  = n;
    pc_raddr  = slot;
    pce_we    = 1'b0;
    pce_waddr = {slot, j[PIECE_AW-1:0]};
    pce_wdata = last;
    pce_raddr = {slot, j[PIECE_AW-1:0]};
    stg_we    = 1'b0;
    stg_waddr = n_m1[PIECE_AW-1:0];
    stg_raddr = j[PIECE_AW-1:0];
    log_we    = 1'b0;
    log_waddr = pops[HEAP_AW-1:0];
    log_raddr = k[HEAP_AW-1:0];
    unique case (state)
      S_INIT: begin
        hreq.valid      = 1'b1;
        hreq.op         = HOP_CLEAR;
        free_units_next = FREE_W'(disk_size);
        slots_used_next = '0;
        state_next      = S_INIT_W;
      end
      S_INIT_W: begin
        if (!hrsp.busy) begin
          if (disk_size != '0) begin
            hreq.valid  = 1'b1;
            hreq.op     = HOP_PUSH;
            hreq.ext.lo = UNIT_W'(1);
            hreq.ext.hi = END_W'(disk_size) + END_W'(1);
            state_next  = S_SEED_W;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_SEED_W: begin
        if (hrsp.done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cfg.valid) begin
          disk_size_next = cfg.disk_size;
          state_next     = S_INIT;
        end else if (item.valid) begin
          cmd_next   = item.command;
          fid_next   = item.file_id;
          fsize_next = item.file_size;
          rs_next    = item.range_start;
          hi_q_next  = END_W'(item.range_end) + END_W'(1);
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        ovf_next   = 1'b0;
        scan_next  = '0;
        total_next = '0;
        unique case (cmd)
          CMD_ADD: begin
            if (FREE_W'(fsize) > free_units) begin
              ans_next   = '1;
              state_next = S_EMIT;
            end else begin
              state_next = S_FIND;
            end
          end
          CMD_REMOVE: state_next = S_FIND;
          CMD_COUNT:  state_next = S_CNT_SLOT;
          default: begin
            ans_next   = '0;
            state_next = S_EMIT;
          end
        endcase
      end
      S_FIND: begin
        if (scan == slots_used) begin
          found_next = 1'b0;
          state_next = S_FOUND;
        end else begin
          state_next = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        if (id_rdata == fid) begin
          found_next = 1'b1;
          slot_next  = scan[FILE_AW-1:0];
          state_next = S_FOUND;
        end else begin
          scan_next  = scan + SLOT_W'(1);
          state_next = S_FIND;
        end
      end
      S_FOUND: begin
        if (cmd == CMD_ADD) begin
          if (!found && (slots_used == SLOT_W'(MAX_FILES))) begin
            ans_next   = '1;
            ovf_next   = 1'b1;
            state_next = S_EMIT;
          end else begin
            n_next     = '0;
            rem_next   = fsize;
            pops_next  = '0;
            state_next = S_ADD_LOOP;
          end
        end else if (!found) begin
          ans_next   = '0;
          state_next = S_EMIT;
        end else begin
          state_next = S_RM_N;
        end
      end
      S_ADD_LOOP: begin
        if ((hrsp.count != '0) && (rem != '0)) begin
          hreq.valid = 1'b1;
          hreq.op    = HOP_POP;
          state_next = S_ADD_POP;
        end else begin
          state_next = S_ADD_COMMIT;
        end
      end
      S_ADD_POP: begin
        if (hrsp.done) begin
          pop_next   = hrsp.ext;
          take_next  = (span > END_W'(rem)) ? rem : SIZE_W'(span);
          log_we     = 1'b1;
          pops_next  = pops + HCNT_W'(1);
          state_next = S_ADD_STEP;
        end
      end
      S_ADD_STEP: begin
        if ((n != '0) && (last.hi == END_W'(pop.lo))) begin
          last_next.hi = end_v;
          rem_next     = rem - take;
        end else if (n >= PCNT_W'(MAX_PIECES)) begin
          k_next = '0;
        end else begin
          stg_we = (n != '0);
          if (n == '0) begin
            first_lo_next = pop.lo;
          end
          last_next.lo = pop.lo;
          last_next.hi = end_v;
          n_next       = n + PCNT_W'(1);
          rem_next     = rem - take;
        end
        if (!((n != '0) && (last.hi == END_W'(pop.lo))) && (n >= PCNT_W'(MAX_PIECES))) begin
          state_next = S_RB;
        end else if ((rem == take) && (pop.hi > end_v)) begin
          hreq.valid  = 1'b1;
          hreq.op     = HOP_PUSH;
          hreq.ext.lo = UNIT_W'(end_v);
          hreq.ext.hi = pop.hi;
          state_next  = S_ADD_PUSHW;
        end else begin
          state_next = S_ADD_LOOP;
        end
      end
      S_ADD_PUSHW: begin
        if (hrsp.done) begin
          state_next = S_ADD_LOOP;
        end
      end
      S_ADD_COMMIT: begin
        slot_next = slot_c;
        if (!found) begin
          slots_used_next = slots_used + SLOT_W'(1);
        end
        id_we           = 1'b1;
        sz_we           = 1'b1;
        pc_we           = 1'b1;
        free_units_next = free_units - FREE_W'(fsize);
        j_next          = '0;
        state_next      = S_CP;
      end
      S_CP: begin
        if (j == n) begin
          ans_next   = (n != '0) ? ANS_W'(first_lo) : '0;
          state_next = S_EMIT;
        end else if (j == n_m1) begin
          pce_we = 1'b1;
          j_next = j + PCNT_W'(1);
        end else begin
          state_next = S_CP_WR;
        end
      end
      S_CP_WR: begin
        pce_we     = 1'b1;
        pce_wdata  = stg_rdata;
        j_next     = j + PCNT_W'(1);
        state_next = S_CP;
      end
      S_RB: begin
        if (k == pops) begin
          ans_next   = '1;
          ovf_next   = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_RB_PUSH;
        end
      end
      S_RB_PUSH: begin
        hreq.valid = 1'b1;
        hreq.op    = HOP_PUSH;
        hreq.ext   = log_rdata;
        state_next = S_RB_W;
      end
      S_RB_W: begin
        if (hrsp.done) begin
          k_next     = k + HCNT_W'(1);
          state_next = S_RB;
        end
      end
      S_RM_N: begin
        n_next     = pc_rdata;
        fsize_next = sz_rdata;
        j_next     = '0;
        if (heap_need > (HCNT_W + 1)'(HEAP_DEPTH)) begin
          ans_next   = '1;
          ovf_next   = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_RM_RD;
        end
      end
      S_RM_RD: begin
        if (j == n) begin
          free_units_next = free_units + FREE_W'(fsize);
          sz_we      = 1'b1;
          sz_waddr   = slot;
          sz_wdata   = '0;
          pc_we      = 1'b1;
          pc_waddr   = slot;
          pc_wdata   = '0;
          ans_next   = ANS_W'(n);
          state_next = S_EMIT;
        end else begin
          state_next = S_RM_PUSH;
        end
      end
      S_RM_PUSH: begin
        hreq.valid = 1'b1;
        hreq.op    = HOP_PUSH;
        hreq.ext   = pce_rdata;
        state_next = S_RM_W;
      end
      S_RM_W: begin
        if (hrsp.done) begin
          j_next     = j + PCNT_W'(1);
          state_next = S_RM_RD;
        end
      end
      S_CNT_SLOT: begin
        pc_raddr = scan[FILE_AW-1:0];
        if (scan == slots_used) begin
          ans_next   = ANS_W'(total);
          state_next = S_EMIT;
        end else begin
          state_next = S_CNT_N;
        end
      end
      S_CNT_N: begin
        n_next     = pc_rdata;
        j_next     = '0;
        state_next = S_CNT_RD;
      end
      S_CNT_RD: begin
        pce_raddr = {scan[FILE_AW-1:0], j[PIECE_AW-1:0]};
        if (j == n) begin
          scan_next  = scan + SLOT_W'(1);
          state_next = S_CNT_SLOT;
        end else begin
          state_next = S_CNT_CMP;
        end
      end
      S_CNT_CMP: begin
        if (r_v > END_W'(l_v)) begin
          total_next = total + SLOT_W'(1);
          scan_next  = scan + SLOT_W'(1);
          state_next = S_CNT_SLOT;
        end else begin
          j_next     = j + PCNT_W'(1);
          state_next = S_CNT_RD;
        end
      end
      S_EMIT: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `EFA_ASSERT_IMP(a_ready_heap_idle, item.ready, !hrsp.busy, "item taken while heap engine busy")
  `EFA_ASSERT(a_slots_bound, slots_used <= SLOT_W'(MAX_FILES), "slot count beyond table size")
  `EFA_ASSERT_IMP(a_free_bound, state != S_INIT, free_units <= FREE_W'(disk_size), "free units exceed disk size")
  `EFA_ASSERT_IMP(a_result_load, $rose(result.valid), $past(state) == S_EMIT, "result not from emit")

endmodule

FILE: test/tb_extent_file_allocator.sv
module tb_extent_file_allocator;
  import efa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 40_000_000;
  localparam logic [ANS_W-1:0] REFUSED = '1;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   file_id;
    logic [SIZE_W-1:0] file_size;
    logic [UNIT_W-1:0] range_start;
    logic [UNIT_W-1:0] range_end;
  } alloc_req_t;

  typedef struct {
    logic [ANS_W-1:0] answer;
    logic             overflow;
  } alloc_rsp_t;

  logic clk;
  logic rst;

  efa_item_if   item();
  efa_result_if result();
  efa_cfg_if    cfg();

  extent_file_allocator u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source),
    .cfg    (cfg.sink)
  );

  // allocator shadow state
  int unsigned disk_units;
  int unsigned free_lo [HEAP_DEPTH];
  int unsigned free_hi [HEAP_DEPTH];
  int unsigned free_cnt;
  int unsigned avail_units;
  int unsigned files_used;
  int unsigned file_ids [MAX_FILES];
  int unsigned file_len [MAX_FILES];
  int unsigned file_npc [MAX_FILES];
  int unsigned pc_lo [MAX_FILES*MAX_PIECES];
  int unsigned pc_hi [MAX_FILES*MAX_PIECES];

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  int unsigned queued_total;
  int unsigned accepted_total;
  int unsigned errors;
  int unsigned cycles;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic void free_swap(int unsigned a, int unsigned b);
    int unsigned t;
    t = free_lo[a]; free_lo[a] = free_lo[b]; free_lo[b] = t;
    t = free_hi[a]; free_hi[a] = free_hi[b]; free_hi[b] = t;
  endfunction

  function automatic void free_push(int unsigned lo, int unsigned hi);
    int unsigned i;
    if (free_cnt >= HEAP_DEPTH) return;
    i = free_cnt;
    free_cnt++;
    free_lo[i] = lo;
    free_hi[i] = hi;
    while (i > 0 && free_lo[(i-1)/2] > free_lo[i]) begin
      free_swap(i, (i-1)/2);
      i = (i-1)/2;
    end
  endfunction

  function automatic void free_pop(output int unsigned lo, output int unsigned hi);
    int unsigned i, c;
    i = 0;
    lo = free_lo[0];
    hi = free_hi[0];
    free_cnt--;
    free_lo[0] = free_lo[free_cnt];
    free_hi[0] = free_hi[free_cnt];
    while (2*i+1 < free_cnt) begin
      c = 2*i+1;
      if (c+1 < free_cnt && free_lo[c] > free_lo[c+1]) c = c+1;
      if (free_lo[i] > free_lo[c]) begin
        free_swap(i, c);
        i = c;
      end else break;
    end
  endfunction

  function automatic void allocator_init(int unsigned units);
    disk_units = units;
    free_cnt = 0;
    avail_units = units;
    files_used = 0;
    if (units > 0) free_push(1, units + 1);
  endfunction

  function automatic int find_file(int unsigned id);
    for (int unsigned i = 0; i < files_used; i++)
      if (file_ids[i] == id) return int'(i);
    return -1;
  endfunction

  function automatic alloc_rsp_t allocate(int unsigned id, int unsigned size);
    alloc_rsp_t r;
    int unsigned plo [MAX_PIECES];
    int unsigned phi [MAX_PIECES];
    int unsigned save_lo [HEAP_DEPTH];
    int unsigned save_hi [HEAP_DEPTH];
    int unsigned n, rem, saved, lo, hi, take, fin, s;
    int slot;
    r.answer = '0;
    r.overflow = 1'b0;
    n = 0;
    rem = size;
    saved = free_cnt;
    slot = find_file(id);
    if (size > avail_units) begin
      r.answer = REFUSED;
      return r;
    end
    if (slot < 0 && files_used >= MAX_FILES) begin
      r.answer = REFUSED;
      r.overflow = 1'b1;
      return r;
    end
    save_lo = free_lo;
    save_hi = free_hi;
    while (free_cnt > 0 && rem > 0) begin
      free_pop(lo, hi);
      take = hi - lo;
      if (take > rem) take = rem;
      fin = lo + take;
      if (n > 0 && phi[n-1] == lo) begin
        phi[n-1] = fin;
      end else begin
        if (n >= MAX_PIECES) begin
          free_lo = save_lo;
          free_hi = save_hi;
          free_cnt = saved;
          r.answer = REFUSED;
          r.overflow = 1'b1;
          return r;
        end
        plo[n] = lo;
        phi[n] = fin;
        n++;
      end
      rem -= take;
      if (rem == 0 && hi > fin) free_push(fin, hi);
    end
    if (slot < 0) begin
      slot = int'(files_used);
      files_used++;
    end
    s = unsigned'(slot);
    file_ids[s] = id;
    file_len[s] = size;
    file_npc[s] = n;
    for (int unsigned i = 0; i < n; i++) begin
      pc_lo[s*MAX_PIECES+i] = plo[i];
      pc_hi[s*MAX_PIECES+i] = phi[i];
    end
    avail_units -= size;
    r.answer = (n > 0) ? ANS_W'(plo[0]) : '0;
    return r;
  endfunction

  function automatic alloc_rsp_t release_file(int unsigned id);
    alloc_rsp_t r;
    int slot;
    int unsigned n;
    r.answer = '0;
    r.overflow = 1'b0;
    slot = find_file(id);
    if (slot < 0) return r;
    n = file_npc[slot];
    if (free_cnt + n > HEAP_DEPTH) begin
      r.answer = REFUSED;
      r.overflow = 1'b1;
      return r;
    end
    for (int unsigned i = 0; i < n; i++)
      free_push(pc_lo[slot*MAX_PIECES+i], pc_hi[slot*MAX_PIECES+i]);
    avail_units += file_len[slot];
    file_len[slot] = 0;
    file_npc[slot] = 0;
    r.answer = ANS_W'(n);
    return r;
  endfunction

  function automatic int unsigned overlap_count(int unsigned first, int unsigned last);
    int unsigned hi, total, a, b, l, rr;
    hi = last + 1;
    total = 0;
    for (int unsigned i = 0; i < files_used; i++) begin
      for (int unsigned j = 0; j < file_npc[i]; j++) begin
        a = pc_lo[i*MAX_PIECES+j];
        b = pc_hi[i*MAX_PIECES+j];
        l = (a > first) ? a : first;
        rr = (b < hi) ? b : hi;
        if (rr > l) begin
          total++;
          break;
        end
      end
    end
    return total;
  endfunction

  function automatic alloc_rsp_t allocator_step(alloc_req_t q);
    alloc_rsp_t r;
    r.answer = '0;
    r.overflow = 1'b0;
    case (q.command)
      CMD_ADD:    r = allocate(q.file_id, q.file_size);
      CMD_REMOVE: r = release_file(q.file_id);
      CMD_COUNT:  r.answer = ANS_W'(overlap_count(q.range_start, q.range_end));
      default:    ;
    endcase
    return r;
  endfunction

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // item driver
  alloc_req_t  cur_req;
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
      burst_left <= 4;
      gap_left <= 0;
    end else begin
      if (item.valid && item.ready) begin
        expected_rsps.push_back(allocator_step(cur_req));
        accepted_total++;
      end
      if (!item.valid || item.ready) begin
        if (pending_reqs.size() > 0 && gap_left == 0) begin
          cur_req = pending_reqs.pop_front();
          item.valid <= 1'b1;
          item.command <= cur_req.command;
          item.file_id <= cur_req.file_id;
          item.file_size <= cur_req.file_size;
          item.range_start <= cur_req.range_start;
          item.range_end <= cur_req.range_end;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          item.valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  // result sink with its own stall pattern
  int unsigned stall_mode;
  int unsigned mode_left;

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      stall_mode <= 0;
      mode_left <= 20;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(5, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: result.ready <= 1'b1;
        1: result.ready <= ($urandom_range(0, 3) != 0);
        default: result.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    alloc_rsp_t e;
    if (!rst && result.valid && result.ready) begin
      if (expected_rsps.size() == 0) begin
        report($sformatf("unexpected item answer=%h", result.answer));
      end else begin
        e = expected_rsps.pop_front();
        if (result.answer !== e.answer)
          report($sformatf("answer %h, expected %h", result.answer, e.answer));
        if (result.overflow !== e.overflow)
          report($sformatf("overflow %b, expected %b", result.overflow, e.overflow));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(input logic [CMD_W-1:0] c, input int unsigned id, input int unsigned size,
                      input int unsigned first, input int unsigned last);
    alloc_req_t q;
    q.command = c;
    q.file_id = ID_W'(id);
    q.file_size = SIZE_W'(size);
    q.range_start = UNIT_W'(first);
    q.range_end = UNIT_W'(last);
    pending_reqs.push_back(q);
    queued_total++;
  endtask

  task automatic wait_idle();
    while (accepted_total != queued_total || expected_rsps.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_disk(input int unsigned units);
    wait_idle();
    cfg.valid <= 1'b1;
    cfg.disk_size <= SIZE_W'(units);
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    allocator_init(units & 32'h00FF_FFFF);
  endtask

  task automatic random_phase(input int unsigned n, input int unsigned pool_n);
    int unsigned pool [64];
    int unsigned r, id, size, a, b;
    pool[0] = 0;
    pool[1] = 32'h7FFF_FFFF;
    for (int i = 2; i < 64; i++) pool[i] = $urandom() & 32'h7FFF_FFFF;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      id = ($urandom_range(0, 19) == 0) ? ($urandom() & 32'h7FFF_FFFF)
                                         : pool[$urandom_range(0, pool_n-1)];
      case ($urandom_range(0, 9))
        0: size = $urandom() & 24'hFFFFFF;
        1: size = 0;
        2, 3: size = $urandom_range(0, disk_units / 4 + 1);
        default: size = $urandom_range(1, disk_units / 32 + 2);
      endcase
      if ($urandom_range(0, 3) == 0) begin
        a = $urandom() & 24'hFFFFFF;
        b = $urandom() & 24'hFFFFFF;
      end else begin
        a = $urandom_range(1, disk_units + 2);
        b = $urandom_range(1, disk_units + 2);
        if (a == 0) a = 1;
        if (b == 0) b = 1;
      end
      if (a == 0) a = 1;
      if (b == 0) b = 1;
      if (r < 45) send(CMD_ADD, id, size, a, b);
      else if (r < 75) send(CMD_REMOVE, id, size, a, b);
      else if (r < 96) send(CMD_COUNT, id, size, a, b);
      else send(CMD_UNUSED, id, size, a, b);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg.valid = 1'b0;
    cfg.disk_size = '0;
    item.valid = 1'b0;
    item.command = '0;
    item.file_id = '0;
    item.file_size = '0;
    item.range_start = '0;
    item.range_end = '0;
    result.ready = 1'b0;
    queued_total = 0;
    accepted_total = 0;
    errors = 0;
    cycles = 0;
    allocator_init(32'(DISK_RESET));
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send(CMD_ADD, 0, 0, 1, 1);
    send(CMD_ADD, 32'h7FFF_FFFF, 32'(DISK_RESET), 1, 1);
    send(CMD_ADD, 5, 1, 1, 1);
    send(CMD_COUNT, 0, 0, 1, 1);
    send(CMD_COUNT, 0, 0, 24'hFFFFFF, 24'hFFFFFF);
    send(CMD_COUNT, 0, 0, 10, 5);
    send(CMD_REMOVE, 32'h7FFF_FFFF, 0, 1, 1);
    send(CMD_REMOVE, 77, 0, 1, 1);
    send(CMD_UNUSED, 32'h7FFF_FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send(CMD_ADD, 5, 24'hFFFFFF, 1, 1);
    send(CMD_ADD, 5, 100, 1, 1);
    send(CMD_ADD, 5, 50, 1, 1);
    send(CMD_COUNT, 0, 0, 1, 24'hFFFFFF);
    send(CMD_COUNT, 0, 0, 100, 150);
    send(CMD_REMOVE, 5, 0, 1, 1);
    send(CMD_ADD, 6, 20, 1, 1);
    send(CMD_COUNT, 0, 0, 1, 24'hFFFFFF);

    write_disk(24'hFFFFFF);
    random_phase(150, 40);

    write_disk(1);
    send(CMD_ADD, 1, 1, 1, 1);
    send(CMD_ADD, 2, 1, 1, 1);
    send(CMD_COUNT, 0, 0, 1, 1);
    send(CMD_REMOVE, 1, 0, 1, 1);
    random_phase(60, 6);

    write_disk(200);
    for (int i = 0; i < 64; i++) send(CMD_ADD, 100 + i, 1, 1, 1);
    for (int i = 0; i < 64; i += 2) send(CMD_REMOVE, 100 + i, 0, 1, 1);
    send(CMD_ADD, 500, 33, 1, 1);
    send(CMD_ADD, 501, 32, 1, 1);
    send(CMD_COUNT, 0, 0, 1, 200);
    random_phase(200, 24);

    write_disk($urandom_range(1000, 100000));
    random_phase(300, 48);

    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: extent_file_allocator.f
+incdir+rtl
rtl/efa_pkg.sv
rtl/efa_if.sv
rtl/efa_ram.sv
rtl/efa_heap.sv
rtl/extent_file_allocator.sv
test/tb_extent_file_allocator.sv
